// ===== rtl/core/pmfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfb_pkg
// Shared constants, codes and helpers of the page-mode mono frame buffer.
// ----------------------------------------------------------------------------
package pmfb_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W        = $clog2(STORE_BYTES);
	localparam int PAGE_W        = 5;

	localparam logic [1:0] MODE_PIXEL  = 2'd0;
	localparam logic [1:0] MODE_COLUMN = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	typedef logic [ADDR_W-1:0] addr_t;

	// rows of one page that lie on the screen
	function automatic logic [7:0] page_row_mask(input logic [PAGE_W-1:0] page);
		logic [7:0] m;
		for (int k = 0; k < 8; k++) begin
			m[k] = (int'({page, 3'(k)}) < SCREEN_HEIGHT);
		end
		return m;
	endfunction

	function automatic addr_t byte_addr(input logic [PAGE_W-1:0] page,
		input logic [7:0] col);
		return ADDR_W'(int'(page) * SCREEN_WIDTH + int'(col));
	endfunction

endpackage

// ===== rtl/core/pmfb_if.sv =====
// ----------------------------------------------------------------------------
// pmfb_req_if / pmfb_rsp_if
// Valid/ready channels for draw commands and readout bytes.
// ----------------------------------------------------------------------------
interface pmfb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] column;
	logic [7:0] row;
	logic       color;
	logic [7:0] column_bits;

	modport source (output valid, mode, column, row, color, column_bits, input ready);
	modport sink   (input valid, mode, column, row, color, column_bits, output ready);
endinterface

interface pmfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== rtl/core/pmfb_ram.sv =====
// ----------------------------------------------------------------------------
// pmfb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/page_mode_mono_frame_buffer.sv =====
// ----------------------------------------------------------------------------
// page_mode_mono_frame_buffer
// 128x64 monochrome frame store, page organized, with pixel and column-strip
// drawing, full clear and page-major readout.
// ----------------------------------------------------------------------------
// The store sits in one RAM of STORE_BYTES bytes (1024) with a registered read
// port, and every draw is a read-modify-write of it, one command at a time.
// After reset, and after each clear command, a clearing pass writes zero to
// one byte per cycle over all STORE_BYTES bytes with req.ready low. A draw
// reads as it is taken and writes back in ST_WRA, a column strip's page b
// byte in ST_WRB (its two page bytes read and written back in turn through the
// single read port); a readout waits in ST_RD until its response can be loaded.
module page_mode_mono_frame_buffer
	import pmfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pmfb_req_if.sink   req,
	pmfb_rsp_if.source rsp
);

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_RD   = 5'b00100,
		ST_WRA  = 5'b01000,
		ST_WRB  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	addr_t      clr_q;
	addr_t      rd_ptr_q;
	logic       rd_last_q;
	addr_t      addr_a_q, addr_b_q;
	logic [7:0] dat_a_q, dat_b_q, msk_a_q, msk_b_q;
	logic       en_a_q, en_b_q, two_q;

	logic       rsp_valid_q;
	logic [7:0] frame_byte_q;
	logic       last_byte_q;

	logic       accept;
	logic       rsp_load;

	logic [2:0]        off;
	logic [PAGE_W-1:0] page_a, page_b;
	logic [7:0]        strip_d, strip_m;
	logic [15:0]       wide_d, wide_m;
	logic [7:0]        mask_a, mask_b;
	logic              col_ok;

	logic       ram_we, ram_re;
	addr_t      ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// strip geometry: page a holds the top part, page b the part that spills over
	assign off     = req.row[2:0];
	assign page_a  = req.row[7:3];
	assign page_b  = page_a + PAGE_W'(1);
	assign strip_d = (req.mode == MODE_COLUMN) ? req.column_bits : {7'b0, req.color};
	assign strip_m = (req.mode == MODE_COLUMN) ? 8'hff : 8'h01;
	assign wide_d  = {8'b0, strip_d} << off;
	assign wide_m  = {8'b0, strip_m} << off;
	assign mask_a  = wide_m[7:0] & page_row_mask(page_a);
	assign mask_b  = wide_m[15:8] & page_row_mask(page_b);
	assign col_ok  = (int'(req.column) < SCREEN_WIDTH);

	assign rsp_load = (state_q == ST_RD) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.mode)
						MODE_PIXEL:  state_d = ST_WRA;
						MODE_COLUMN: state_d = ST_WRA;
						MODE_CLEAR:  state_d = ST_CLR;
						MODE_READ:   state_d = ST_RD;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD: begin
				if (rsp_load) state_d = ST_IDLE;
			end
			ST_WRA: begin
				state_d = two_q ? ST_WRB : ST_IDLE;
			end
			ST_WRB: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 8'h00;
		ram_re    = 1'b0;
		ram_raddr = byte_addr(page_a, req.column);
		case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ram_re = accept && (req.mode != MODE_CLEAR);
				if (req.mode == MODE_READ) ram_raddr = rd_ptr_q;
			end
			ST_WRA: begin
				ram_we    = en_a_q;
				ram_waddr = addr_a_q;
				ram_wdata = (ram_rdata & ~msk_a_q) | (dat_a_q & msk_a_q);
				ram_re    = two_q;
				ram_raddr = addr_b_q;
			end
			ST_WRB: begin
				ram_we    = en_b_q;
				ram_waddr = addr_b_q;
				ram_wdata = (ram_rdata & ~msk_b_q) | (dat_b_q & msk_b_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pmfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rd_ptr_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (accept && req.mode == MODE_CLEAR) begin
				clr_q    <= '0;
				rd_ptr_q <= '0;
			end
			if (accept && req.mode == MODE_READ) begin
				rd_ptr_q <= (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + ADDR_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_last_q <= (rd_ptr_q == LAST_ADDR);
			addr_a_q  <= byte_addr(page_a, req.column);
			addr_b_q  <= byte_addr(page_b, req.column);
			dat_a_q   <= wide_d[7:0];
			dat_b_q   <= wide_d[15:8];
			msk_a_q   <= mask_a;
			msk_b_q   <= mask_b;
			en_a_q    <= col_ok && (mask_a != 8'h00);
			en_b_q    <= col_ok && (mask_b != 8'h00);
			two_q     <= (req.mode == MODE_COLUMN);
		end
		if (rsp_load) begin
			frame_byte_q <= ram_rdata;
			last_byte_q  <= rd_last_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.frame_byte = frame_byte_q;
	assign rsp.last_byte  = last_byte_q;

	// the clearing pass never runs with a nonzero read pointer
	a_clr_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> rd_ptr_q == '0)
		else $error("read pointer nonzero during clearing pass");

	// a clear command restarts the pass at the first byte
	a_clr_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.mode == MODE_CLEAR |=> state_q == ST_CLR && clr_q == '0)
		else $error("clear command did not restart clearing pass");

	// the store is never written while commands are being taken
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != ST_IDLE)
		else $error("store written in idle state");

	// a pending response is not overwritten before it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(frame_byte_q))
		else $error("pending response lost");

endmodule

// ===== verif/page_mode_mono_frame_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_mode_mono_frame_buffer_tb
// Drives draw, clear and readout commands into the frame buffer with random
// idling on both channels. A shadow copy of the frame store predicts every
// readout byte and its last-byte flag, which are checked in order.
// ----------------------------------------------------------------------------
module page_mode_mono_frame_buffer_tb;
	import pmfb_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] column;
		logic [7:0] row;
		logic       color;
		logic [7:0] column_bits;
	} draw_cmd_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_read_t;

	logic clk = 1'b0;
	logic arst_n;

	pmfb_req_if req();
	pmfb_rsp_if rsp();

	page_mode_mono_frame_buffer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// shadow copy of the frame and its readout pointer
	logic [7:0]  shadow_frame [STORE_BYTES];
	int          shadow_read_ptr = 0;
	frame_read_t pending_bytes [$];

	int fail_count    = 0;
	int bytes_checked = 0;
	int cmds_sent     = 0;
	int clears_sent   = 0;
	int cycle_count   = 0;
	bit steady_send   = 1'b0;
	int ready_run     = 0;
	logic ready_level = 1'b0;

	initial begin
		foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;
	end

	function automatic void draw_pixel(int x, int y, logic lit);
		int addr;
		if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
		addr = x + (y / 8) * SCREEN_WIDTH;
		shadow_frame[addr][y % 8] = lit;
	endfunction

	function automatic void apply_command(draw_cmd_t cmd);
		frame_read_t rd;
		case (cmd.mode)
			MODE_PIXEL: begin
				draw_pixel(int'(cmd.column), int'(cmd.row), cmd.color);
			end
			MODE_COLUMN: begin
				// each strip pixel clipped on its own, row sum wraps at 256
				for (int i = 0; i < 8; i++)
					draw_pixel(int'(cmd.column), (int'(cmd.row) + i) % 256,
						cmd.column_bits[i]);
			end
			MODE_CLEAR: begin
				foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;
				shadow_read_ptr = 0;
			end
			default: begin
				if (shadow_read_ptr >= STORE_BYTES) shadow_read_ptr = 0;
				rd.frame_byte = shadow_frame[shadow_read_ptr];
				rd.last_byte  = (shadow_read_ptr == STORE_BYTES - 1);
				shadow_read_ptr = rd.last_byte ? 0 : shadow_read_ptr + 1;
				pending_bytes.push_back(rd);
			end
		endcase
	endfunction

	// mostly short gaps, a few long ones, and stretches with none
	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 47) == 0) steady_send = !steady_send;
		if (steady_send) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_cmd(logic [1:0] mode, logic [7:0] column, logic [7:0] row,
		logic color, logic [7:0] column_bits);
		draw_cmd_t cmd;
		int gap;
		cmd = '{mode, column, row, color, column_bits};
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.mode        <= cmd.mode;
		req.column      <= cmd.column;
		req.row         <= cmd.row;
		req.color       <= cmd.color;
		req.column_bits <= cmd.column_bits;
		@(posedge clk);
		while (req.ready !== 1'b1) @(posedge clk);
		apply_command(cmd);
		cmds_sent++;
		if (cmd.mode == MODE_CLEAR) clears_sent++;
	endtask

	// unused fields carry random values
	task automatic read_bytes(int n);
		repeat (n) send_cmd(MODE_READ, 8'($urandom), 8'($urandom), 1'($urandom),
			8'($urandom));
	endtask

	task automatic clear_frame();
		send_cmd(MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] pick_column();
		if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, SCREEN_WIDTH - 1));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_row();
		if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, SCREEN_HEIGHT - 1));
		return 8'($urandom);
	endfunction

	task automatic test_pixel_extremes();
		send_cmd(MODE_PIXEL, 8'd0, 8'd0, 1'b1, 8'($urandom));
		send_cmd(MODE_PIXEL, 8'(SCREEN_WIDTH - 1), 8'd0, 1'b1, 8'($urandom));
		send_cmd(MODE_PIXEL, 8'd0, 8'(SCREEN_HEIGHT - 1), 1'b1, 8'($urandom));
		send_cmd(MODE_PIXEL, 8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1), 1'b1, 8'hFF);
		// off the screen: must leave the store alone
		send_cmd(MODE_PIXEL, 8'(SCREEN_WIDTH), 8'd5, 1'b1, 8'h00);
		send_cmd(MODE_PIXEL, 8'd5, 8'(SCREEN_HEIGHT), 1'b1, 8'h00);
		send_cmd(MODE_PIXEL, 8'hFF, 8'hFF, 1'b1, 8'hFF);
		send_cmd(MODE_PIXEL, 8'd1, 8'd7, 1'b1, 8'h00);
		send_cmd(MODE_PIXEL, 8'd1, 8'd7, 1'b0, 8'h00);
	endtask

	task automatic test_column_strips();
		send_cmd(MODE_COLUMN, 8'd2, 8'd3, 1'b0, 8'hFF);     // spans two pages
		send_cmd(MODE_COLUMN, 8'd3, 8'd60, 1'b1, 8'hFF);    // runs off the bottom
		send_cmd(MODE_COLUMN, 8'd4, 8'd252, 1'b0, 8'hA5);   // wraps to the top rows
		send_cmd(MODE_COLUMN, 8'd200, 8'd0, 1'b1, 8'hFF);   // off the screen
		send_cmd(MODE_COLUMN, 8'd2, 8'd8, 1'b0, 8'h00);     // dark strip
		send_cmd(MODE_COLUMN, 8'(SCREEN_WIDTH - 1), 8'd56, 1'b1, 8'h5A);
	endtask

	task automatic test_clear_resets_pointer();
		read_bytes(5);
		clear_frame();
		read_bytes(2);
	endtask

	task automatic test_random_mix();
		int n;
		int r;
		int burst;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 38) begin
				send_cmd(MODE_PIXEL, pick_column(), pick_row(), 1'($urandom), 8'($urandom));
				n++;
			end else if (r < 70) begin
				send_cmd(MODE_COLUMN, pick_column(), pick_row(), 1'($urandom),
					8'($urandom));
				n++;
			end else if (r < 72) begin
				clear_frame();
				n++;
			end else begin
				burst = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : 1;
				read_bytes(burst);
				n += burst;
			end
		end
	endtask

	// response side: stretches of ready high and low
	always @(posedge clk) begin
		int r;
		if (ready_run == 0) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				ready_level = 1'b1;
				ready_run   = $urandom_range(1, 8);
			end else if (r < 85) begin
				ready_level = 1'b0;
				ready_run   = $urandom_range(1, 3);
			end else if (r < 95) begin
				ready_level = 1'b0;
				ready_run   = $urandom_range(10, 40);
			end else begin
				ready_level = 1'b1;
				ready_run   = $urandom_range(50, 200);
			end
		end else begin
			ready_run--;
		end
		rsp.ready <= ready_level;
	end

	// readout byte check against the oldest prediction
	always @(posedge clk) begin
		frame_read_t exp_byte;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_bytes.size() == 0) begin
				$error("readout byte %h with no read outstanding", rsp.frame_byte);
				fail_count++;
			end else begin
				exp_byte = pending_bytes.pop_front();
				if (rsp.frame_byte !== exp_byte.frame_byte) begin
					$error("frame_byte mismatch: expected %h, actual %h",
						exp_byte.frame_byte, rsp.frame_byte);
					fail_count++;
				end
				if (rsp.last_byte !== exp_byte.last_byte) begin
					$error("last_byte mismatch: expected %b, actual %b",
						exp_byte.last_byte, rsp.last_byte);
					fail_count++;
				end
				bytes_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL page_mode_mono_frame_buffer");
			$finish;
		end
	end

	initial begin
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.mode        <= MODE_PIXEL;
		req.column      <= 8'h00;
		req.row         <= 8'h00;
		req.color       <= 1'b0;
		req.column_bits <= 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_pixel_extremes();
		test_column_strips();
		test_clear_resets_pointer();
		test_random_mix();

		req.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands (%0d clears) with random idling on both sides",
			cmds_sent, clears_sent);
		$display("checked %0d readout bytes against the shadow frame", bytes_checked);
		if (fail_count == 0) begin
			$display("PASS page_mode_mono_frame_buffer");
		end else begin
			$display("FAIL page_mode_mono_frame_buffer");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pmfb_pkg.sv
rtl/core/pmfb_if.sv
rtl/core/pmfb_ram.sv
rtl/core/page_mode_mono_frame_buffer.sv
verif/page_mode_mono_frame_buffer_tb.sv
